/* rtl/hnpd_pkg.sv */
// ----------------------------------------------------------------------------
// hnpd_pkg
// Shared types, codes and classifiers for the heading numbering prefix detector.
// ----------------------------------------------------------------------------
`default_nettype none
package hnpd_pkg;
  localparam int CP_W     = 21;
  localparam int NB_W     = 3;
  localparam int POS_W    = 10;
  localparam int DEPTH_W  = 6;
  localparam int KIND_W   = 3;
  localparam int DEF_MAX_LINE_BYTES = 1023;
  localparam int POS_CAP  = 1023;

  localparam logic [KIND_W-1:0] KIND_NONE    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_CHAPTER = 3'd1;
  localparam logic [KIND_W-1:0] KIND_SECTION = 3'd2;
  localparam logic [KIND_W-1:0] KIND_PAREN   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_DOTTED  = 3'd4;
  localparam logic [KIND_W-1:0] KIND_ARABIC  = 3'd5;
  localparam logic [KIND_W-1:0] KIND_DUNHAO  = 3'd6;

  localparam logic [CP_W-1:0] CP_DI     = 21'h07B2C;
  localparam logic [CP_W-1:0] CP_ZHANG  = 21'h07AE0;
  localparam logic [CP_W-1:0] CP_BIAN   = 21'h07F16;
  localparam logic [CP_W-1:0] CP_JIE    = 21'h08282;
  localparam logic [CP_W-1:0] CP_PIAN   = 21'h07BC7;
  localparam logic [CP_W-1:0] CP_BU     = 21'h090E8;
  localparam logic [CP_W-1:0] CP_FEN    = 21'h05206;
  localparam logic [CP_W-1:0] CP_LPAREN_W = 21'h0FF08;
  localparam logic [CP_W-1:0] CP_RPAREN_W = 21'h0FF09;
  localparam logic [CP_W-1:0] CP_LPAREN = 21'h00028;
  localparam logic [CP_W-1:0] CP_RPAREN = 21'h00029;
  localparam logic [CP_W-1:0] CP_DUNHAO = 21'h03001;
  localparam logic [CP_W-1:0] CP_CJK_LO = 21'h02E80;
  localparam logic [CP_W-1:0] CP_DOT_W  = 21'h0FF0E;
  localparam logic [CP_W-1:0] CP_DOT    = 21'h0002E;
  localparam logic [CP_W-1:0] CP_IDSP   = 21'h03000;
  localparam logic [CP_W-1:0] CP_LDQ    = 21'h0201C;
  localparam logic [CP_W-1:0] CP_LCB    = 21'h0300C;

  // classification of one codepoint, computed in the front part
  typedef struct packed {
    logic [CP_W-1:0]  cp;
    logic [POS_W-1:0] pos;
    logic             fed;   // codepoint reaches the trackers
    logic             last;
    logic             space;
    logic             digit;
    logic             han;
  } cls_t;

  function automatic logic is_han_num(input logic [CP_W-1:0] c);
    unique case (c)
      21'h03007, 21'h096F6, 21'h04E00, 21'h04E24, 21'h04E8C, 21'h04E09,
      21'h056DB, 21'h04E94, 21'h0516D, 21'h04E03, 21'h0516B, 21'h04E5D,
      21'h05341, 21'h0767E, 21'h05343, 21'h04E07: is_han_num = 1'b1;
      default: is_han_num = 1'b0;
    endcase
  endfunction
endpackage
`default_nettype wire

/* rtl/hnpd_front.sv */
// ----------------------------------------------------------------------------
// hnpd_front
// Accepts codepoints, tracks byte position and leading space, classifies.
// ----------------------------------------------------------------------------
`default_nettype none
module hnpd_front import hnpd_pkg::*; #(
  parameter int MAX_LINE_BYTES = DEF_MAX_LINE_BYTES
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic [CP_W-1:0] cp,
  input  wire logic [NB_W-1:0] nb,
  input  wire logic            last,
  output logic                 q_valid,
  input  wire logic            q_ready,
  output cls_t                 q_data
);
  localparam int LIMIT_I = (MAX_LINE_BYTES < POS_CAP) ? MAX_LINE_BYTES : POS_CAP;
  localparam logic [POS_W:0] LIMIT = (POS_W+1)'(LIMIT_I);

  logic [POS_W-1:0] pos;
  logic             lead;
  logic [POS_W:0]   sum;
  logic [POS_W-1:0] pos_next;
  logic             sp;
  logic             take;

  assign in_ready = !q_valid || q_ready;
  assign take     = in_valid && in_ready;
  assign sum      = {1'b0, pos} + {{(POS_W+1-NB_W){1'b0}}, nb};
  assign pos_next = (sum > LIMIT) ? LIMIT[POS_W-1:0] : sum[POS_W-1:0];
  assign sp       = ((cp >= 21'd1) && (cp <= 21'd32)) || (cp == CP_IDSP);

  always_ff @(posedge clk) begin
    if (rst) begin
      pos     <= '0;
      lead    <= 1'b1;
      q_valid <= 1'b0;
    end else begin
      if (take) begin
        pos     <= last ? '0 : pos_next;
        lead    <= last ? 1'b1 : (lead && sp);
        q_valid <= 1'b1;
      end else if (q_ready) begin
        q_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      q_data.cp    <= cp;
      q_data.pos   <= pos_next;
      q_data.fed   <= !(lead && sp);
      q_data.last  <= last;
      q_data.space <= sp;
      q_data.digit <= (cp >= 21'h30) && (cp <= 21'h39);
      q_data.han   <= is_han_num(cp);
    end
  end
endmodule
`default_nettype wire

/* rtl/hnpd_back.sv */
// ----------------------------------------------------------------------------
// hnpd_back
// Runs the five prefix trackers and resolves one result per line.
// ----------------------------------------------------------------------------
`default_nettype none
module hnpd_back import hnpd_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               q_valid,
  output logic                    q_ready,
  input  cls_t                    q_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [KIND_W-1:0]       kind,
  output logic [DEPTH_W-1:0]      depth,
  output logic [POS_W-1:0]        plen
);
  localparam logic [2:0] ST_DONE = 3'd7;
  localparam logic [3:0] HAN_MAX = 4'd8;

  typedef struct packed {
    logic [2:0]         s0, s1, s2, s3, s4;
    logic [3:0]         h0, h1, h2;
    logic [1:0]         dr;
    logic [DEPTH_W-1:0] dg;
    logic [4:0]         mv;
    logic [POS_W-1:0]   l0, l1, l2, l3, l4;
    logic [DEPTH_W-1:0] d0, d1, d2;  // depths that vary: chapter, paren, dotted
  } trk_t;

  trk_t st, a, b;
  logic take;
  logic [KIND_W-1:0]  r_kind;
  logic [DEPTH_W-1:0] r_dep;
  logic [POS_W-1:0]   r_len;

  function automatic trk_t feed(input trk_t t, input logic [CP_W-1:0] c,
                                input logic [POS_W-1:0] e, input logic sp,
                                input logic dg, input logic hn);
    trk_t n;
    logic close;
    n = t;
    close = (c == CP_RPAREN_W) || (c == CP_RPAREN);
    // ordinal chapter / section
    unique case (t.s0)
      3'd0: if (c == CP_DI) n.s0 = 3'd1; else begin n.s0 = ST_DONE; n.mv[0] = 1'b0; end
      3'd1: if (hn) begin n.s0 = 3'd2; n.h0 = 4'd1; end
            else if (dg) n.s0 = 3'd3;
            else begin n.s0 = ST_DONE; n.mv[0] = 1'b0; end
      3'd2, 3'd3: begin
        if (t.s0 == 3'd2 && hn && t.h0 < HAN_MAX) n.h0 = t.h0 + 4'd1;
        else if (t.s0 == 3'd3 && dg) n.s0 = t.s0;
        else if (c == CP_ZHANG || c == CP_BIAN) begin
          n.s0 = ST_DONE; n.mv[0] = 1'b1; n.l0 = e; n.d0 = 6'd1;
        end else if (c == CP_JIE || c == CP_PIAN) begin
          n.s0 = ST_DONE; n.mv[0] = 1'b1; n.l0 = e; n.d0 = 6'd2;
        end else if (c == CP_BU) n.s0 = 3'd4;
        else begin n.s0 = ST_DONE; n.mv[0] = 1'b0; end
      end
      3'd4: begin
        n.s0 = ST_DONE; n.mv[0] = (c == CP_FEN);
        if (c == CP_FEN) begin n.l0 = e; n.d0 = 6'd1; end
      end
      default: ;
    endcase
    // bracketed ordinal
    unique case (t.s1)
      3'd0: if (c == CP_LPAREN_W || c == CP_LPAREN) n.s1 = 3'd1;
            else begin n.s1 = ST_DONE; n.mv[1] = 1'b0; end
      3'd1: if (!sp) begin
              if (hn) begin n.s1 = 3'd2; n.h1 = 4'd1; end
              else if (dg) n.s1 = 3'd3;
              else begin n.s1 = ST_DONE; n.mv[1] = 1'b0; end
            end
      3'd2, 3'd3, 3'd4, 3'd5: begin
        if (t.s1 == 3'd2 && hn && t.h1 < HAN_MAX) n.h1 = t.h1 + 4'd1;
        else if (t.s1 == 3'd3 && dg) n.s1 = t.s1;
        else begin
          n.s1 = (t.s1 == 3'd2 || t.s1 == 3'd4) ? 3'd4 : 3'd5;
          if (!sp) begin
            n.s1 = ST_DONE; n.mv[1] = close;
            if (close) begin
              n.l1 = e;
              n.d1 = (t.s1 == 3'd2 || t.s1 == 3'd4) ? 6'd2 : 6'd3;
            end
          end
        end
      end
      default: ;
    endcase
    // dotted decimal
    unique case (t.s2)
      3'd0: if (dg) begin n.s2 = 3'd1; n.dg = 6'd1; end
            else begin n.s2 = ST_DONE; n.mv[2] = 1'b0; end
      3'd1: if (c == CP_DOT) n.s2 = 3'd2;
            else if (!dg) begin n.s2 = ST_DONE; n.mv[2] = 1'b0; end
      3'd2: if (dg) begin
              n.s2 = 3'd3; n.l2 = e;
              if (t.dg < 6'd63) n.dg = t.dg + 6'd1;
            end else begin
              n.s2 = ST_DONE; n.mv[2] = (t.dg > 6'd1);
              if (t.dg > 6'd1) n.d2 = t.dg;
            end
      3'd3: if (dg) n.l2 = e;
            else if (c == CP_DOT) n.s2 = 3'd2;
            else begin n.s2 = ST_DONE; n.mv[2] = 1'b1; n.d2 = t.dg; end
      default: ;
    endcase
    // short Arabic number with a mark
    unique case (t.s3)
      3'd0: if (dg) begin n.s3 = 3'd1; n.dr = 2'd1; end
            else begin n.s3 = ST_DONE; n.mv[3] = 1'b0; end
      3'd1: if (dg) begin
              if (t.dr >= 2'd3) begin n.s3 = ST_DONE; n.mv[3] = 1'b0; end
              else n.dr = t.dr + 2'd1;
            end else if (c == CP_DOT || c == CP_DOT_W || c == CP_DUNHAO) begin
              n.s3 = 3'd2; n.l3 = e;
            end else begin n.s3 = ST_DONE; n.mv[3] = 1'b0; end
      3'd2: begin
        n.s3 = ST_DONE;
        n.mv[3] = sp || (c >= CP_CJK_LO) || (c == CP_LDQ) || (c == CP_LCB);
      end
      default: ;
    endcase
    // Han numerals with ideographic comma
    unique case (t.s4)
      3'd0: if (hn) begin n.s4 = 3'd1; n.h2 = 4'd1; end
            else begin n.s4 = ST_DONE; n.mv[4] = 1'b0; end
      3'd1: if (hn && t.h2 < HAN_MAX) n.h2 = t.h2 + 4'd1;
            else begin
              n.s4 = ST_DONE; n.mv[4] = (t.h2 <= 4'd6) && (c == CP_DUNHAO);
              if (n.mv[4]) n.l4 = e;
            end
      default: ;
    endcase
    return n;
  endfunction

  // only a line end needs the output slot; other codepoints keep flowing
  assign q_ready = !out_valid || out_ready || !q_data.last;
  assign take    = q_valid && q_ready;

  always_comb begin
    a = q_data.fed ? feed(st, q_data.cp, q_data.pos, q_data.space, q_data.digit,
                          q_data.han) : st;
    b = feed(a, '0, q_data.pos, 1'b0, 1'b0, 1'b0);
    priority if (b.mv[0]) begin
      r_kind = (b.d0 == 6'd2) ? KIND_SECTION : KIND_CHAPTER;
      r_dep = b.d0; r_len = b.l0;
    end else if (b.mv[1]) begin
      r_kind = KIND_PAREN; r_dep = b.d1; r_len = b.l1;
    end else if (b.mv[2]) begin
      r_kind = KIND_DOTTED; r_dep = b.d2; r_len = b.l2;
    end else if (b.mv[3]) begin
      r_kind = KIND_ARABIC; r_dep = 6'd3; r_len = b.l3;
    end else if (b.mv[4]) begin
      r_kind = KIND_DUNHAO; r_dep = 6'd1; r_len = b.l4;
    end else begin
      r_kind = KIND_NONE; r_dep = '0; r_len = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= '0;
      out_valid <= 1'b0;
    end else begin
      if (take) begin
        st <= q_data.last ? '0 : a;
      end
      if (take && q_data.last) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && q_data.last) begin
      kind  <= r_kind;
      depth <= r_dep;
      plen  <= r_len;
    end
  end
endmodule
`default_nettype wire

/* rtl/heading_numbering_prefix_detect.sv */
// ----------------------------------------------------------------------------
// heading_numbering_prefix_detect
// Per-line detection of a heading numbering prefix over a codepoint stream.
// ----------------------------------------------------------------------------
// Input channel s_axis_*: one codepoint per item with its UTF-8 byte count
// and tlast on the last codepoint of a line. Output channel m_axis_*: one
// item per line, carrying kind, depth prior and prefix length in bytes.
// Result path: the front registers the classified codepoint when it takes it,
// and the tracker stage registers the line's result when it takes that last
// codepoint from the front, which waits while the output slot is full.
// Throughput: one codepoint per cycle when neither side stalls; the front and
// the trackers are parted by a one-entry register queue, and a tracker stall backs up into the front.
// The per-codepoint rate is set by the tracker update, a single compare
// stage over five small state machines.
// Reset (rst, synchronous) clears byte position, trackers and both valid
// flags. A stalled receiver holds the result; the trackers keep taking
// codepoints of the next line until a new line end needs the output slot.
// ----------------------------------------------------------------------------
`default_nettype none
module heading_numbering_prefix_detect import hnpd_pkg::*; #(
  parameter int MAX_LINE_BYTES = DEF_MAX_LINE_BYTES
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,  // codepoint[20:0], cp_bytes[23:21]
  input  wire logic        s_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata   // kind[2:0], depth[8:3], prefix_bytes[18:9]
);
  logic               q_valid;
  logic               q_ready;
  cls_t               q_data;
  logic [KIND_W-1:0]  kind;
  logic [DEPTH_W-1:0] depth;
  logic [POS_W-1:0]   plen;

  // classify codepoints and count bytes
  hnpd_front #(.MAX_LINE_BYTES(MAX_LINE_BYTES)) u_front (
    .clk(clk), .rst(rst),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .cp(s_axis_tdata[20:0]), .nb(s_axis_tdata[23:21]), .last(s_axis_tlast),
    .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data)
  );

  // advance trackers and resolve at line end
  hnpd_back u_back (
    .clk(clk), .rst(rst),
    .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .kind(kind), .depth(depth), .plen(plen)
  );

  assign m_axis_tdata = {5'd0, plen, depth, kind};
endmodule
`default_nettype wire

/* rtl/hnpd_checker.sv */
// ----------------------------------------------------------------------------
// hnpd_checker
// Port-level checks of the detector, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module hnpd_checker import hnpd_pkg::*; (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        s_axis_tlast,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [23:0] m_axis_tdata
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped or changed under stall");
  a_kind: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[2:0] <= KIND_DUNHAO)
    else $error("kind out of range");
  a_none: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[2:0] == KIND_NONE |-> m_axis_tdata[18:3] == '0)
    else $error("no match with nonzero fields");
  a_nolast: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid && !$past(s_axis_tvalid && s_axis_tready && s_axis_tlast) |=>
      !m_axis_tvalid || $past(m_axis_tvalid) ||
      $past(s_axis_tvalid && s_axis_tready && s_axis_tlast, 2))
    else $error("result without line end");
endmodule

bind heading_numbering_prefix_detect hnpd_checker u_hnpd_checker (
  .clk(clk), .rst(rst),
  .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
  .s_axis_tlast(s_axis_tlast),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata)
);
`default_nettype wire

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the heading numbering prefix detector: directed
// lines, then random lines biased toward well-formed numbering prefixes,
// with random idling on both sides and one long output stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

import hnpd_pkg::*;

typedef struct packed {
  logic [KIND_W-1:0]  kind;
  logic [DEPTH_W-1:0] depth;
  logic [POS_W-1:0]   plen;
} heading_t;

// Predicts one heading result per line and checks the block's results in order.
class heading_board;
  heading_t expq[$];
  int       errors;
  // tracker state, mirrored per line
  int unsigned pos, lead;
  int unsigned stp[5];
  int unsigned hrun[3];
  int unsigned drun, groups;
  int unsigned mok[5], mlen[5], mdep[5];

  function new();
    errors = 0;
    clear_line();
  endfunction

  function void clear_line();
    pos = 0; lead = 1; drun = 0; groups = 0;
    for (int t = 0; t < 5; t++) begin
      stp[t] = 0; mok[t] = 0; mlen[t] = 0; mdep[t] = 0;
    end
    for (int t = 0; t < 3; t++) hrun[t] = 0;
  endfunction

  function bit sp(int unsigned c);
    return (c >= 1 && c <= 32) || c == CP_IDSP;
  endfunction

  function bit dg(int unsigned c);
    return c >= 'h30 && c <= 'h39;
  endfunction

  function bit hn(int unsigned c);
    case (c)
      'h3007, 'h96F6, 'h4E00, 'h4E24, 'h4E8C, 'h4E09, 'h56DB, 'h4E94,
      'h516D, 'h4E03, 'h516B, 'h4E5D, 'h5341, 'h767E, 'h5343, 'h4E07: return 1;
      default: return 0;
    endcase
  endfunction

  function void close_trk(int t, bit ok, int unsigned len, int unsigned dep);
    mok[t] = ok;
    if (ok) begin
      mlen[t] = len; mdep[t] = dep;
    end
    stp[t] = 7;
  endfunction

  function void ordinal_tail(int unsigned c, int unsigned e);
    if (c == CP_ZHANG || c == CP_BIAN) close_trk(0, 1, e, 1);
    else if (c == CP_JIE || c == CP_PIAN) close_trk(0, 1, e, 2);
    else if (c == CP_BU) stp[0] = 4;
    else close_trk(0, 0, 0, 0);
  endfunction

  function void bracket_close(int unsigned c, int unsigned e, int unsigned d);
    if (sp(c)) return;
    close_trk(1, c == CP_RPAREN_W || c == CP_RPAREN, e, d);
  endfunction

  function void advance(int unsigned c, int unsigned e);
    case (stp[0])
      0: if (c == CP_DI) stp[0] = 1; else close_trk(0, 0, 0, 0);
      1: if (hn(c)) begin stp[0] = 2; hrun[0] = 1; end
         else if (dg(c)) stp[0] = 3;
         else close_trk(0, 0, 0, 0);
      2: if (hn(c) && hrun[0] < 8) hrun[0]++; else ordinal_tail(c, e);
      3: if (!dg(c)) ordinal_tail(c, e);
      4: close_trk(0, c == CP_FEN, e, 1);
      default: ;
    endcase
    case (stp[1])
      0: if (c == CP_LPAREN_W || c == CP_LPAREN) stp[1] = 1; else close_trk(1, 0, 0, 0);
      1: if (!sp(c)) begin
           if (hn(c)) begin stp[1] = 2; hrun[1] = 1; end
           else if (dg(c)) stp[1] = 3;
           else close_trk(1, 0, 0, 0);
         end
      2: if (hn(c) && hrun[1] < 8) hrun[1]++;
         else begin stp[1] = 4; bracket_close(c, e, 2); end
      3: if (!dg(c)) begin stp[1] = 5; bracket_close(c, e, 3); end
      4: bracket_close(c, e, 2);
      5: bracket_close(c, e, 3);
      default: ;
    endcase
    case (stp[2])
      0: if (dg(c)) begin stp[2] = 1; groups = 1; end else close_trk(2, 0, 0, 0);
      1: if (c == CP_DOT) stp[2] = 2; else if (!dg(c)) close_trk(2, 0, 0, 0);
      2: if (dg(c)) begin
           stp[2] = 3;
           if (groups < 63) groups++;
           mlen[2] = e;
         end else close_trk(2, groups > 1, mlen[2], groups);
      3: if (dg(c)) mlen[2] = e;
         else if (c == CP_DOT) stp[2] = 2;
         else close_trk(2, 1, mlen[2], groups);
      default: ;
    endcase
    case (stp[3])
      0: if (dg(c)) begin stp[3] = 1; drun = 1; end else close_trk(3, 0, 0, 0);
      1: if (dg(c)) begin
           if (drun >= 3) close_trk(3, 0, 0, 0); else drun++;
         end else if (c == CP_DOT || c == CP_DOT_W || c == CP_DUNHAO) begin
           stp[3] = 2; mlen[3] = e;
         end else close_trk(3, 0, 0, 0);
      2: close_trk(3, sp(c) || c >= CP_CJK_LO || c == CP_DUNHAO || c == CP_LDQ ||
                   c == CP_LCB, mlen[3], 3);
      default: ;
    endcase
    case (stp[4])
      0: if (hn(c)) begin stp[4] = 1; hrun[2] = 1; end else close_trk(4, 0, 0, 0);
      1: if (hn(c) && hrun[2] < 8) hrun[2]++;
         else close_trk(4, hrun[2] <= 6 && c == CP_DUNHAO, e, 1);
      default: ;
    endcase
  endfunction

  // Note one accepted codepoint; queue a result at the line end.
  function void note_item(logic [CP_W-1:0] cp, logic [NB_W-1:0] nb, logic eol);
    heading_t r;
    pos += nb;
    if (pos > POS_CAP) pos = POS_CAP;
    if (!(lead && sp(cp))) begin
      lead = 0;
      advance(cp, pos);
    end
    if (!eol) return;
    advance(0, pos);
    r = '0;
    for (int t = 0; t < 5; t++) begin
      if (mok[t]) begin
        if (t == 0) r.kind = (mdep[0] == 2) ? KIND_SECTION : KIND_CHAPTER;
        else r.kind = KIND_W'(t + 2);
        r.depth = DEPTH_W'(mdep[t]);
        r.plen  = POS_W'(mlen[t]);
        break;
      end
    end
    expq.push_back(r);
    clear_line();
  endfunction

  function void check_result(logic [23:0] data);
    heading_t e, a;
    a.kind = data[2:0]; a.depth = data[8:3]; a.plen = data[18:9];
    if (expq.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected result kind=%0d depth=%0d len=%0d",
                                 a.kind, a.depth, a.plen);
      return;
    end
    e = expq.pop_front();
    if (a !== e || data[23:19] !== '0) begin
      errors++;
      if (errors <= 10)
        $display("mismatch: exp kind=%0d depth=%0d len=%0d, got kind=%0d depth=%0d len=%0d",
                 e.kind, e.depth, e.plen, a.kind, a.depth, a.plen);
    end
  endfunction
endclass

module testbench;
  logic        clk, rst;
  logic        s_axis_tvalid, s_axis_tready, s_axis_tlast;
  logic [23:0] s_axis_tdata;   // codepoint[20:0], cp_bytes[23:21]
  logic        m_axis_tvalid, m_axis_tready;
  logic [23:0] m_axis_tdata;   // kind[2:0], depth[8:3], prefix_bytes[18:9]

  heading_board board;
  int          idle_cycles;
  bit          hold_sink;

  heading_numbering_prefix_detect u_top (.*);

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // Sample both handshakes at the rising edge; feed the scoreboard.
  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready)
        board.note_item(s_axis_tdata[20:0], s_axis_tdata[23:21], s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles > 20000) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Gap length: half the time none, else mostly short, sometimes long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Receiver: random ready, plus one long hold-off while input keeps flowing.
  initial begin
    int g;
    m_axis_tready = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_sink) begin
        m_axis_tready <= 0;
        repeat (300) @(negedge clk);
        hold_sink = 0;
      end
      g = pick_gap();
      if (g > 0) begin
        m_axis_tready <= 0;
        repeat (g) @(negedge clk);
      end
      m_axis_tready <= 1;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
  end

  // Offer one codepoint, hold until taken, then insert an optional gap.
  task automatic send_cp(int unsigned cp, int unsigned nb, bit eol, bit no_gap = 0);
    int g;
    s_axis_tvalid <= 1;
    s_axis_tdata  <= {NB_W'(nb), CP_W'(cp)};
    s_axis_tlast  <= eol;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
    g = no_gap ? 0 : pick_gap();
    if (g > 0) begin
      s_axis_tvalid <= 0;
      repeat (g) @(negedge clk);
    end
  endtask

  // UTF-8 length for a codepoint, the natural encoding.
  function automatic int unsigned utf8_len(int unsigned cp);
    if (cp < 'h80) return 1;
    if (cp < 'h800) return 2;
    if (cp < 'h10000) return 3;
    return 4;
  endfunction

  task automatic send_line(int unsigned cps[$], bit no_gap = 0);
    for (int i = 0; i < cps.size(); i++)
      send_cp(cps[i], utf8_len(cps[i]), i == cps.size() - 1, no_gap);
  endtask

  function automatic int unsigned han_digit();
    int unsigned tab[16] = '{'h3007, 'h96F6, 'h4E00, 'h4E24, 'h4E8C, 'h4E09, 'h56DB,
      'h4E94, 'h516D, 'h4E03, 'h516B, 'h4E5D, 'h5341, 'h767E, 'h5343, 'h4E07};
    return tab[$urandom_range(15)];
  endfunction

  function automatic int unsigned any_cp();
    int unsigned pool[14] = '{CP_DOT, CP_DOT_W, CP_DUNHAO, CP_RPAREN, CP_RPAREN_W,
      CP_LDQ, CP_LCB, CP_ZHANG, CP_JIE, CP_FEN, 'h20, 'h41, 'h3000, 'h4E2D};
    int r;
    r = $urandom_range(9);
    if (r < 3) return $urandom_range('h30, 'h39);
    if (r < 5) return han_digit();
    if (r < 8) return pool[$urandom_range(13)];
    if (r < 9) return $urandom_range(0, 'h1FFFFF);
    return $urandom_range(1, 'h2FFFF);
  endfunction

  // Random line: leading spaces, for most shapes a numbering prefix, then body text.
  // Add the line's codepoint count to count.
  task automatic random_line(ref int count, input bit no_gap = 0);
    int unsigned l[$];
    int unsigned tails[6] = '{CP_ZHANG, CP_BIAN, CP_JIE, CP_PIAN, CP_BU, 'h41};
    int n, shape;
    repeat ($urandom_range(0, 3)) l.push_back($urandom_range(1) ? 'h20 : CP_IDSP);
    shape = $urandom_range(7);
    case (shape)
      0: begin
        l.push_back(CP_DI);
        n = $urandom_range(1, 10);
        if ($urandom_range(1)) repeat (n) l.push_back(han_digit());
        else repeat (n) l.push_back($urandom_range('h30, 'h39));
        l.push_back(tails[$urandom_range(5)]);
        if (l[l.size()-1] == CP_BU) l.push_back($urandom_range(3) ? CP_FEN : 'h41);
      end
      1: begin
        l.push_back($urandom_range(1) ? CP_LPAREN : CP_LPAREN_W);
        if ($urandom_range(1)) l.push_back('h20);
        n = $urandom_range(1, 10);
        if ($urandom_range(1)) repeat (n) l.push_back(han_digit());
        else repeat (n) l.push_back($urandom_range('h30, 'h39));
        if ($urandom_range(1)) l.push_back('h20);
        l.push_back($urandom_range(3) ? ($urandom_range(1) ? CP_RPAREN : CP_RPAREN_W)
                                      : 'h41);
      end
      2: begin
        n = $urandom_range(1, 5);
        for (int g = 0; g < n; g++) begin
          repeat ($urandom_range(1, 3)) l.push_back($urandom_range('h30, 'h39));
          if (g < n - 1 || $urandom_range(1)) l.push_back(CP_DOT);
        end
      end
      3: begin
        repeat ($urandom_range(1, 4)) l.push_back($urandom_range('h30, 'h39));
        l.push_back($urandom_range(2) == 0 ? CP_DOT : ($urandom_range(1) ? CP_DOT_W
                                                                         : CP_DUNHAO));
      end
      4: begin
        repeat ($urandom_range(1, 9)) l.push_back(han_digit());
        l.push_back($urandom_range(3) ? CP_DUNHAO : 'h41);
      end
      default: ;
    endcase
    repeat ($urandom_range(0, 6)) l.push_back(any_cp());
    if (l.size() == 0) l.push_back(any_cp());
    count += l.size();
    send_line(l, no_gap);
  endtask

  initial begin
    int sent;
    bit held;
    int unsigned l[$];
    board = new();
    rst = 1; s_axis_tvalid = 0; s_axis_tdata = '0; s_axis_tlast = 0;
    idle_cycles = 0; hold_sink = 0;
    repeat (9) @(negedge clk);
    rst <= 0;
    @(negedge clk);

    // Directed lines: every kind, spaces, codepoint zero, odd byte counts.
    send_line('{CP_DI, 'h4E00, CP_ZHANG, 'h41});
    send_line('{'h20, CP_DI, 'h31, 'h32, CP_JIE});
    send_line('{CP_DI, 'h4E09, CP_BU, CP_FEN});
    send_line('{CP_LPAREN_W, 'h4E00, CP_RPAREN_W});
    send_line('{CP_LPAREN, 'h20, 'h37, 'h20, CP_RPAREN});
    send_line('{'h31, CP_DOT, 'h32, CP_DOT, 'h33});
    send_line('{'h31, 'h32, CP_DOT_W, 'h4E2D});
    send_line('{'h31, CP_DOT, 'h1FFFFF});
    send_line('{'h4E8C, CP_DUNHAO, 'h41});
    send_line('{'h20, CP_IDSP, 'h20});
    send_line('{'h31, 0, CP_DOT, 'h32});
    send_line('{0});
    send_cp(CP_DI, 0, 0); send_cp('h31, 7, 0); send_cp(CP_ZHANG, 5, 1);
    send_cp('h4E00, 6, 0); send_cp(CP_DUNHAO, 4, 1);
    // Long line: a large byte position and deep dotted groups.
    for (int g = 0; g < 70; g++) begin
      l.push_back('h39); l.push_back(CP_DOT);
    end
    l.push_back('h39);
    repeat (150) l.push_back('h10FFFF);
    send_line(l);

    // Random lines; partway through stall the receiver for a long stretch.
    sent = 0;
    held = 0;
    while (sent < 1250) begin
      if (sent > 500 && !held) begin
        hold_sink = 1;
        held = 1;
      end
      random_line(sent, sent > 500 && sent < 900);
    end
    s_axis_tvalid <= 0;
    s_axis_tlast  <= 0;

    while (board.expq.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (board.errors == 0 && board.expq.size() == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule

`default_nettype wire

/* sim.f */
rtl/hnpd_pkg.sv
rtl/hnpd_front.sv
rtl/hnpd_back.sv
rtl/heading_numbering_prefix_detect.sv
rtl/hnpd_checker.sv
tb/testbench.sv
